@@ hdl/csq_pkg.sv @@
// shared types, codes and widths for the cursor sequence store
package csq_pkg;

    localparam int DEPTH_DEF   = 32;
    localparam int MODE_W      = 4;
    localparam int VALUE_W     = 64;
    localparam int COUNT_OUT_W = 6;
    localparam int STATUS_W    = 2;

    localparam logic [MODE_W-1:0] MODE_START      = 4'd0;
    localparam logic [MODE_W-1:0] MODE_ADVANCE    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT     = 4'd2;
    localparam logic [MODE_W-1:0] MODE_ATTACH     = 4'd3;
    localparam logic [MODE_W-1:0] MODE_FRONT_PUSH = 4'd4;
    localparam logic [MODE_W-1:0] MODE_FRONT_POP  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_BACK_PUSH  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_BACK_POP   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 4'd8;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic take;
        logic exec;
        logic load;
    } csq_cmd_t;

endpackage

@@ hdl/csq_ctrl.sv @@
// controller state machine: input beat, execute, result load
module csq_ctrl
    import csq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    output logic     result_valid,
    input  logic     result_ready,
    output csq_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       result_valid_reg;
    logic       result_valid_next;

    always_comb
    begin
        cmd.take   = (state_reg == ST_IDLE) && item_valid;
        cmd.exec   = (state_reg == ST_EXEC);
        cmd.load   = (state_reg == ST_LOAD) && (!result_valid_reg || result_ready);
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

@@ hdl/csq_datapath.sv @@
// datapath: row of shifting entry cells, count, cursor and result registers
module csq_datapath
    import csq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  csq_cmd_t               cmd,
    input  logic [MODE_W-1:0]      mode,
    input  logic [VALUE_W-1:0]     value,
    output logic [VALUE_W-1:0]     current_value,
    output logic [COUNT_OUT_W-1:0] entry_count,
    output logic                   has_item,
    output logic [STATUS_W-1:0]    status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [MODE_W-1:0]      mode_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [VALUE_W-1:0]     entries_reg [DEPTH];
    logic [VALUE_W-1:0]     entries_next [DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       cursor_reg;
    logic [CNT_W-1:0]       cursor_next;
    logic [STATUS_W-1:0]    status_reg;
    logic [STATUS_W-1:0]    status_next;
    logic [VALUE_W-1:0]     current_value_reg;
    logic [COUNT_OUT_W-1:0] entry_count_reg;
    logic                   has_item_reg;
    logic [STATUS_W-1:0]    status_out_reg;

    logic             full;
    logic             empty;
    logic             do_put;
    logic             do_drop;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] attach_pos;
    logic [CNT_W-1:0] cursor_op;

    // operation decode
    always_comb
    begin
        full        = (count_reg == FULL_CNT);
        empty       = (count_reg == '0);
        do_put      = 1'b0;
        do_drop     = 1'b0;
        pos         = '0;
        cursor_op   = cursor_reg;
        status_next = STATUS_OK;
        attach_pos  = empty ? '0 : cursor_reg + 1'b1;
        if (attach_pos > count_reg)
        begin
            attach_pos = count_reg;
        end
        unique case (mode_reg) inside
            MODE_START:
            begin
                cursor_op = '0;
            end
            MODE_ADVANCE:
            begin
                if (cursor_reg < count_reg)
                begin
                    cursor_op = cursor_reg + 1'b1;
                end
            end
            MODE_INSERT, MODE_ATTACH, MODE_FRONT_PUSH, MODE_BACK_PUSH:
            begin
                if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    do_put = 1'b1;
                    case (mode_reg)
                        MODE_INSERT:
                        begin
                            pos = cursor_reg;
                        end
                        MODE_ATTACH:
                        begin
                            pos       = attach_pos;
                            cursor_op = attach_pos;
                        end
                        MODE_FRONT_PUSH:
                        begin
                            pos = '0;
                        end
                        default:
                        begin
                            pos = count_reg;
                        end
                    endcase
                end
            end
            MODE_FRONT_POP, MODE_BACK_POP, MODE_REMOVE:
            begin
                if (empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    case (mode_reg)
                        MODE_FRONT_POP:
                        begin
                            do_drop = 1'b1;
                            pos     = '0;
                        end
                        MODE_BACK_POP:
                        begin
                            do_drop = 1'b1;
                            pos     = count_reg - 1'b1;
                        end
                        default:
                        begin
                            do_drop = (cursor_reg < count_reg);
                            pos     = cursor_reg;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        count_next  = count_reg;
        cursor_next = cursor_op;
        if (do_put)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_drop)
        begin
            count_next = count_reg - 1'b1;
            if (cursor_op > count_next)
            begin
                cursor_next = count_next;
            end
        end
    end

    // each cell takes its own word, a neighbour's or the new value
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (do_put)
            begin
                if (CNT_W'(i) == pos)
                begin
                    entries_next[i] = value_reg;
                end
                else if ((i > 0) && (CNT_W'(i) > pos))
                begin
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_drop && (i < DEPTH - 1) && (CNT_W'(i) >= pos))
            begin
                entries_next[i] = entries_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mode_reg  <= mode;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            entries_reg <= entries_next;
            status_reg  <= status_next;
        end
        if (cmd.load)
        begin
            current_value_reg <= (cursor_reg < count_reg) ?
                                 entries_reg[cursor_reg[IDX_W-1:0]] : '0;
            entry_count_reg   <= COUNT_OUT_W'(count_reg);
            has_item_reg      <= (cursor_reg < count_reg);
            status_out_reg    <= status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    assign current_value = current_value_reg;
    assign entry_count   = entry_count_reg;
    assign has_item      = has_item_reg;
    assign status        = status_out_reg;

endmodule

@@ hdl/cursor_sequence_store.sv @@
// top level of the cursor sequence store
//
//  channel  valid         ready         payload
//  item     item_valid    item_ready    mode, value
//  result   result_valid  result_ready  current_value, entry_count, has_item, status
//
// an item passes three steps: input beat, shift of the cell row, read at the cursor
// no new item is taken until the previous one has left the read step
// a result held by result_ready low does not block the next input beat
// a further result waits in the read stage until the output register frees
// rst_n clears count, cursor and handshake state; entry cells hold no reset
module cursor_sequence_store
    import csq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [MODE_W-1:0]      mode,
    input  logic [VALUE_W-1:0]     value,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [VALUE_W-1:0]     current_value,
    output logic [COUNT_OUT_W-1:0] entry_count,
    output logic                   has_item,
    output logic [STATUS_W-1:0]    status
);

    csq_cmd_t cmd;

    csq_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    csq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .mode          (mode),
        .value         (value),
        .current_value (current_value),
        .entry_count   (entry_count),
        .has_item      (has_item),
        .status        (status)
    );

endmodule
